FILE: design/tcw_pkg.sv
// shared types, constants and helpers of the text console writer
package tcw_pkg;

   // default screen geometry
   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   // field widths of the request and response words
   localparam int KIND_W       = 2;
   localparam int CHAR_W       = 8;
   localparam int ATTR_W       = 8;
   localparam int HEX_W        = 32;
   localparam int INDEX_W      = 11;
   localparam int EMIT_W       = 4;
   localparam int CURSOR_OUT_W = 11;
   localparam int CELL_W       = CHAR_W + ATTR_W;
   localparam int NIBBLE_W     = 4;
   localparam int HEX_CNT_W    = 4;

   // character codes and fixed values
   localparam logic [CHAR_W-1:0]    NEWLINE_CODE   = 8'd10;
   localparam logic [CHAR_W-1:0]    CHAR_ZERO      = 8'h30;
   localparam logic [CHAR_W-1:0]    CHAR_X         = 8'h78;
   localparam logic [ATTR_W-1:0]    ATTR_RESET     = 8'd7;
   localparam logic [EMIT_W-1:0]    EMIT_ONE       = 4'd1;
   localparam logic [EMIT_W-1:0]    EMIT_HEX       = 4'd10;
   localparam logic [HEX_CNT_W-1:0] HEX_PREFIX_CNT = 4'd2;
   localparam logic [HEX_CNT_W-1:0] HEX_LAST_IDX   = 4'd9;

   // request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR = 2'd0,
      KIND_CHAR  = 2'd1,
      KIND_HEX   = 2'd2,
      KIND_READ  = 2'd3
   } tcw_kind_type;

   // controller states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_WIPE,
      ST_CHAR,
      ST_PRIME,
      ST_COPY,
      ST_ZERO,
      ST_FINISH
   } tcw_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic sweep_clear;
      logic sweep_step;
      logic wipe_wr;
      logic copy_rd;
      logic copy_wr;
      logic cursor_home;
      logic cursor_up;
      logic emit;
      logic mark_scroll;
      logic respond;
   } tcw_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic past_end;
      logic sweep_at_end;
      logic sweep_at_copy_end;
      logic hex_done;
      logic rsp_busy;
   } tcw_status_type;

   // lowercase hex digit for one nibble
   function automatic logic [CHAR_W-1:0] hex_char(input logic [NIBBLE_W-1:0] nib);
      logic [CHAR_W-1:0] c;
      case (nib)
         4'h0: c = 8'h30;
         4'h1: c = 8'h31;
         4'h2: c = 8'h32;
         4'h3: c = 8'h33;
         4'h4: c = 8'h34;
         4'h5: c = 8'h35;
         4'h6: c = 8'h36;
         4'h7: c = 8'h37;
         4'h8: c = 8'h38;
         4'h9: c = 8'h39;
         4'ha: c = 8'h61;
         4'hb: c = 8'h62;
         4'hc: c = 8'h63;
         4'hd: c = 8'h64;
         4'he: c = 8'h65;
         4'hf: c = 8'h66;
         default: c = 8'h30;
      endcase
      return c;
   endfunction

endpackage

FILE: design/tcw_if.sv
// request and response channel interfaces of the text console writer

interface tcw_req_if;
   import tcw_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [CHAR_W-1:0]   char_code;
   logic [HEX_W-1:0]    hex_value;
   logic [INDEX_W-1:0]  cell_index;

   modport source (output valid, kind, char_code, hex_value, cell_index, input ready);
   modport sink   (input valid, kind, char_code, hex_value, cell_index, output ready);
endinterface

interface tcw_rsp_if;
   import tcw_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [EMIT_W-1:0]        chars_emitted;
   logic [CURSOR_OUT_W-1:0]  cursor_cell;
   logic                     scrolled;
   logic [CHAR_W-1:0]        read_char;
   logic [ATTR_W-1:0]        read_attribute;

   modport source (output valid, chars_emitted, cursor_cell, scrolled, read_char,
                   read_attribute, input ready);
   modport sink   (input valid, chars_emitted, cursor_cell, scrolled, read_char,
                   read_attribute, output ready);
endinterface

FILE: design/tcw_controller.sv
// sequencing state machine of the text console writer
module tcw_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  tcw_pkg::tcw_kind_type   req_kind,
   output logic                    req_ready,
   input  tcw_pkg::tcw_status_type status,
   output tcw_pkg::tcw_cmd_type    cmd
);
   import tcw_pkg::*;

   tcw_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (status.sweep_at_end) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  KIND_CLEAR: state_in = ST_WIPE;
                  KIND_CHAR:  state_in = ST_CHAR;
                  KIND_HEX:   state_in = ST_CHAR;
                  KIND_READ:  state_in = ST_FINISH;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_WIPE: begin
            if (status.sweep_at_end) state_in = ST_FINISH;
         end
         ST_CHAR: begin
            if (status.past_end) begin
               state_in = ST_PRIME;
            end else if (status.hex_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_PRIME: begin
            state_in = ST_COPY;
         end
         ST_COPY: begin
            if (status.sweep_at_copy_end) state_in = ST_ZERO;
         end
         ST_ZERO: begin
            if (status.sweep_at_end) state_in = ST_CHAR;
         end
         ST_FINISH: begin
            if (!status.rsp_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.wipe_wr    = 1'b1;
            cmd.sweep_step = 1'b1;
            if (status.sweep_at_end) cmd.cursor_home = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_kind == KIND_CLEAR) cmd.sweep_clear = 1'b1;
            end
         end
         ST_WIPE: begin
            cmd.wipe_wr    = 1'b1;
            cmd.sweep_step = 1'b1;
            if (status.sweep_at_end) cmd.cursor_home = 1'b1;
         end
         ST_CHAR: begin
            if (status.past_end) begin
               cmd.mark_scroll = 1'b1;
               cmd.sweep_clear = 1'b1;
            end else begin
               cmd.emit = 1'b1;
            end
         end
         ST_PRIME: begin
            cmd.copy_rd = 1'b1;
         end
         ST_COPY: begin
            cmd.copy_wr    = 1'b1;
            cmd.copy_rd    = 1'b1;
            cmd.sweep_step = 1'b1;
         end
         ST_ZERO: begin
            cmd.wipe_wr    = 1'b1;
            cmd.sweep_step = 1'b1;
            if (status.sweep_at_end) cmd.cursor_up = 1'b1;
         end
         ST_FINISH: begin
            if (!status.rsp_busy) cmd.respond = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: design/tcw_datapath.sv
// cell store, cursor, hex digit sequencer and response register
module tcw_datapath #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tcw_pkg::tcw_cmd_type                 cmd,
   output tcw_pkg::tcw_status_type              status,
   input  logic [tcw_pkg::KIND_W-1:0]           req_kind,
   input  logic [tcw_pkg::CHAR_W-1:0]           req_char_code,
   input  logic [tcw_pkg::HEX_W-1:0]            req_hex_value,
   input  logic [tcw_pkg::INDEX_W-1:0]          req_cell_index,
   input  logic                                 csr_wr_en,
   input  logic [tcw_pkg::ATTR_W-1:0]           csr_wr_data,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [tcw_pkg::EMIT_W-1:0]           rsp_chars_emitted,
   output logic [tcw_pkg::CURSOR_OUT_W-1:0]     rsp_cursor_cell,
   output logic                                 rsp_scrolled,
   output logic [tcw_pkg::CHAR_W-1:0]           rsp_read_char,
   output logic [tcw_pkg::ATTR_W-1:0]           rsp_read_attribute
);
   import tcw_pkg::*;

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int CUR_W      = $clog2(CELL_COUNT + 1);
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int IDX_CMP_W  = (CUR_W > INDEX_W) ? CUR_W : INDEX_W;

   localparam logic [CUR_W-1:0]     CELL_END   = CUR_W'(CELL_COUNT);
   localparam logic [CUR_W-1:0]     ROW_STEP   = CUR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0]    SWEEP_LAST = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0]    COPY_LAST  = ADDR_W'(CELL_COUNT - COLUMNS - 1);
   localparam logic [COL_W-1:0]     COL_LAST   = COL_W'(COLUMNS - 1);
   localparam logic [IDX_CMP_W-1:0] IDX_LIMIT  = IDX_CMP_W'(CELL_COUNT);

   // cell store: attribute in the high byte, character in the low byte
   logic [CELL_W-1:0] screen_mem [CELL_COUNT];
   logic [CELL_W-1:0] rd_data_ff;

   logic [ATTR_W-1:0]    attr_ff, attr_in;
   logic [ADDR_W-1:0]    sweep_ff, sweep_in;
   logic [CUR_W-1:0]     cursor_ff, cursor_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   tcw_kind_type         kind_ff, kind_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic [HEX_W-1:0]     hex_shift_ff, hex_shift_in;
   logic [HEX_CNT_W-1:0] hex_cnt_ff, hex_cnt_in;
   logic [ADDR_W-1:0]    idx_addr_ff, idx_addr_in;
   logic                 idx_ok_ff, idx_ok_in;
   logic                 scrolled_ff, scrolled_in;

   logic [EMIT_W-1:0]       rsp_emit_ff, rsp_emit_in;
   logic [CURSOR_OUT_W-1:0] rsp_cursor_ff, rsp_cursor_in;
   logic                    rsp_scrolled_ff, rsp_scrolled_in;
   logic [CHAR_W-1:0]       rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0]       rsp_attr_ff, rsp_attr_in;

   logic [IDX_CMP_W-1:0] req_idx_wide;
   logic [CHAR_W-1:0]    cur_char;
   logic                 is_newline;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_addr;
   logic [CELL_W-1:0]    mem_wdata;
   logic [ADDR_W-1:0]    rd_addr;

   assign req_idx_wide = IDX_CMP_W'(req_cell_index);

   // character that the current emit step prints
   always_comb begin
      if (kind_ff == KIND_CHAR) begin
         cur_char = char_ff;
      end else if (hex_cnt_ff == '0) begin
         cur_char = CHAR_ZERO;
      end else if (hex_cnt_ff == HEX_CNT_W'(1)) begin
         cur_char = CHAR_X;
      end else begin
         cur_char = hex_char(hex_shift_ff[HEX_W-1 -: NIBBLE_W]);
      end
   end
   assign is_newline = (cur_char == NEWLINE_CODE);

   // status back to the controller
   always_comb begin
      status.past_end          = (cursor_ff == CELL_END);
      status.sweep_at_end      = (sweep_ff == SWEEP_LAST);
      status.sweep_at_copy_end = (sweep_ff == COPY_LAST);
      status.hex_done          = (kind_ff != KIND_HEX) || (hex_cnt_ff == HEX_LAST_IDX);
      status.rsp_busy          = rsp_valid_ff && !rsp_ready;
   end

   // sweep counter for wipe, copy and row zeroing
   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep_clear) begin
         sweep_in = '0;
      end else if (cmd.sweep_step && (sweep_ff != SWEEP_LAST)) begin
         sweep_in = sweep_ff + ADDR_W'(1);
      end
   end

   // cursor and column tracking
   always_comb begin
      cursor_in = cursor_ff;
      col_in    = col_ff;
      if (cmd.cursor_home) begin
         cursor_in = '0;
         col_in    = '0;
      end else if (cmd.cursor_up) begin
         cursor_in = cursor_ff - ROW_STEP;
         col_in    = '0;
      end else if (cmd.emit) begin
         if (is_newline) begin
            cursor_in = cursor_ff - CUR_W'(col_ff) + ROW_STEP;
            col_in    = '0;
         end else begin
            cursor_in = cursor_ff + CUR_W'(1);
            col_in    = (col_ff == COL_LAST) ? '0 : col_ff + COL_W'(1);
         end
      end
   end

   // attribute register
   assign attr_in = csr_wr_en ? csr_wr_data : attr_ff;

   // request capture and hex digit sequencing
   always_comb begin
      kind_in      = kind_ff;
      char_in      = char_ff;
      hex_shift_in = hex_shift_ff;
      hex_cnt_in   = hex_cnt_ff;
      idx_addr_in  = idx_addr_ff;
      idx_ok_in    = idx_ok_ff;
      scrolled_in  = scrolled_ff;
      if (cmd.capture) begin
         kind_in      = tcw_kind_type'(req_kind);
         char_in      = req_char_code;
         hex_shift_in = req_hex_value;
         hex_cnt_in   = '0;
         idx_addr_in  = ADDR_W'(req_idx_wide);
         idx_ok_in    = (req_idx_wide < IDX_LIMIT);
         scrolled_in  = 1'b0;
      end else begin
         if (cmd.emit) begin
            hex_cnt_in = hex_cnt_ff + HEX_CNT_W'(1);
            if (hex_cnt_ff >= HEX_PREFIX_CNT) begin
               hex_shift_in = {hex_shift_ff[HEX_W-NIBBLE_W-1:0], NIBBLE_W'(0)};
            end
         end
         if (cmd.mark_scroll) scrolled_in = 1'b1;
      end
   end

   // store write port and read address
   always_comb begin
      mem_we    = cmd.wipe_wr || cmd.copy_wr || (cmd.emit && !is_newline);
      mem_addr  = (cmd.wipe_wr || cmd.copy_wr) ? sweep_ff : ADDR_W'(cursor_ff);
      if (cmd.wipe_wr) begin
         mem_wdata = '0;
      end else if (cmd.copy_wr) begin
         mem_wdata = rd_data_ff;
      end else begin
         mem_wdata = {attr_ff, cur_char};
      end
      if (cmd.capture) begin
         rd_addr = ADDR_W'(req_idx_wide);
      end else if (cmd.copy_rd) begin
         rd_addr = ADDR_W'(CUR_W'(sweep_in) + ROW_STEP);
      end else begin
         rd_addr = idx_addr_ff;
      end
   end

   // response word
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_emit_in     = rsp_emit_ff;
      rsp_cursor_in   = rsp_cursor_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      rsp_char_in     = rsp_char_ff;
      rsp_attr_in     = rsp_attr_ff;
      if (cmd.respond) begin
         rsp_valid_in    = 1'b1;
         rsp_cursor_in   = CURSOR_OUT_W'(cursor_ff);
         rsp_scrolled_in = scrolled_ff;
         rsp_char_in     = '0;
         rsp_attr_in     = '0;
         case (kind_ff)
            KIND_CHAR: rsp_emit_in = EMIT_ONE;
            KIND_HEX:  rsp_emit_in = EMIT_HEX;
            default:   rsp_emit_in = '0;
         endcase
         if ((kind_ff == KIND_READ) && idx_ok_ff) begin
            rsp_char_in = rd_data_ff[CHAR_W-1:0];
            rsp_attr_in = rd_data_ff[CELL_W-1:CHAR_W];
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= ATTR_RESET;
         sweep_ff     <= '0;
         cursor_ff    <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         attr_ff      <= attr_in;
         sweep_ff     <= sweep_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff         <= kind_in;
      char_ff         <= char_in;
      hex_shift_ff    <= hex_shift_in;
      hex_cnt_ff      <= hex_cnt_in;
      idx_addr_ff     <= idx_addr_in;
      idx_ok_ff       <= idx_ok_in;
      scrolled_ff     <= scrolled_in;
      rsp_emit_ff     <= rsp_emit_in;
      rsp_cursor_ff   <= rsp_cursor_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
      rsp_char_ff     <= rsp_char_in;
      rsp_attr_ff     <= rsp_attr_in;
   end

   // cell store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= screen_mem[rd_addr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_chars_emitted  = rsp_emit_ff;
   assign rsp_cursor_cell    = rsp_cursor_ff;
   assign rsp_scrolled       = rsp_scrolled_ff;
   assign rsp_read_char      = rsp_char_ff;
   assign rsp_read_attribute = rsp_attr_ff;

endmodule

FILE: design/text_console_writer.sv
// text console writer top level: controller plus datapath
// a print past the last cell scrolls the screen: the cells are copied up one row,
// one cell per cycle through the single store write port, then the last row is zeroed
// a new request is taken only after the previous one has issued its response word
// reset: a clearing pass over all COLUMNS*ROWS cells (2000 by default) runs first with
// req ready low; csr writes are taken throughout
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   tcw_req_if.sink                     req_port,
   tcw_rsp_if.source                   rsp_port,
   input  logic                        csr_wr_en,
   input  logic [tcw_pkg::ATTR_W-1:0]  csr_wr_data
);
   import tcw_pkg::*;

   tcw_cmd_type    cmd;
   tcw_status_type status;

   // sequencing
   tcw_controller u_tcw_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_kind  (tcw_kind_type'(req_port.kind)),
      .req_ready (req_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // store, cursor and response
   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_tcw_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_kind           (req_port.kind),
      .req_char_code      (req_port.char_code),
      .req_hex_value      (req_port.hex_value),
      .req_cell_index     (req_port.cell_index),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_ready          (rsp_port.ready),
      .rsp_valid          (rsp_port.valid),
      .rsp_chars_emitted  (rsp_port.chars_emitted),
      .rsp_cursor_cell    (rsp_port.cursor_cell),
      .rsp_scrolled       (rsp_port.scrolled),
      .rsp_read_char      (rsp_port.read_char),
      .rsp_read_attribute (rsp_port.read_attribute)
   );

endmodule

FILE: design/tcw_checker.sv
// port-level checks of the text console writer and their binding
module tcw_checker #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_ready,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [tcw_pkg::EMIT_W-1:0]          rsp_chars_emitted,
   input  logic [tcw_pkg::CURSOR_OUT_W-1:0]    rsp_cursor_cell,
   input  logic                                rsp_scrolled,
   input  logic [tcw_pkg::CHAR_W-1:0]          rsp_read_char,
   input  logic [tcw_pkg::ATTR_W-1:0]          rsp_read_attribute
);
   import tcw_pkg::*;

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam logic CURSOR_WRAPS = (CELL_COUNT >= (1 << CURSOR_OUT_W));
   localparam logic [CURSOR_OUT_W-1:0] CURSOR_MAX = CURSOR_OUT_W'(CELL_COUNT);

   // a pending response word stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   // the clearing pass after reset blocks requests
   a_reset_wipe: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("request accepted before the store was cleared");

   // cursor never beyond one past the last cell
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CURSOR_WRAPS || (rsp_cursor_cell <= CURSOR_MAX)))
      else $error("cursor past the end of the screen");

   // only clear, read, character and hex counts occur; only printing scrolls
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_chars_emitted == EMIT_ONE || rsp_chars_emitted == EMIT_HEX)
         || (rsp_chars_emitted == '0 && !rsp_scrolled)))
      else $error("bad emitted count or scroll without printing");

   // printing requests return no cell bytes
   a_print_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_chars_emitted != '0) |->
         (rsp_read_char == '0) && (rsp_read_attribute == '0))
      else $error("cell bytes on a printing response");

endmodule

bind text_console_writer tcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcw_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_port.ready),
   .rsp_valid          (rsp_port.valid),
   .rsp_ready          (rsp_port.ready),
   .rsp_chars_emitted  (rsp_port.chars_emitted),
   .rsp_cursor_cell    (rsp_port.cursor_cell),
   .rsp_scrolled       (rsp_port.scrolled),
   .rsp_read_char      (rsp_port.read_char),
   .rsp_read_attribute (rsp_port.read_attribute)
);
